// ===== rtl/lrp_pkg.sv =====
// Shared constants, codes and types of the LR parse engine.
`default_nettype none
package lrp_pkg;

  // Sizes of the stores
  localparam int STATES          = 256;
  localparam int SYMBOLS         = 64;
  localparam int RULES           = 128;
  localparam int STACK_DEPTH     = 256;
  localparam int MAX_RULE_LENGTH = 15;
  localparam int CHARS           = 256;
  localparam int REDUCE_LIMIT    = 4096;

  localparam int ST_W     = $clog2(STATES);
  localparam int SYM_W    = $clog2(SYMBOLS);
  localparam int RULE_AW  = $clog2(RULES);
  localparam int LEN_W    = $clog2(MAX_RULE_LENGTH + 1);
  localparam int STK_AW   = $clog2(STACK_DEPTH);
  localparam int CNT_W    = $clog2(STACK_DEPTH + 1);
  localparam int CHAR_W   = $clog2(CHARS);
  localparam int ACT_AW   = ST_W + SYM_W;
  localparam int ACT_DEPTH = STATES * SYMBOLS;
  localparam int CLR_W    = $clog2(ACT_DEPTH + 1);
  localparam int BUDGET_W = $clog2(REDUCE_LIMIT + 1);
  localparam int KIND_W   = 2;
  localparam int VAL_W    = 8;
  localparam int ACT_W    = KIND_W + VAL_W;
  localparam int RULE_W   = LEN_W + SYM_W;
  localparam int MAP_W    = SYM_W + 1;

  // Commands carried on in_tuser
  typedef enum logic [2:0] {
    CMD_ACT_WR  = 3'd0,
    CMD_RULE_WR = 3'd1,
    CMD_MAP_WR  = 3'd2,
    CMD_START   = 3'd3,
    CMD_CHAR    = 3'd4,
    CMD_END     = 3'd5
  } cmd_e;

  // Action entry kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_ERROR  = 2'd0,
    KIND_SHIFT  = 2'd1,
    KIND_REDUCE = 2'd2,
    KIND_ACCEPT = 2'd3
  } kind_e;

  // Result status and sticky verdict
  typedef enum logic [1:0] {
    STAT_DONE    = 2'd0,
    STAT_PENDING = 2'd1,
    STAT_ACCEPT  = 2'd2,
    STAT_REJECT  = 2'd3
  } status_e;

  // Sequencer states
  typedef enum logic [2:0] {
    SQ_CLEAR,
    SQ_IDLE,
    SQ_MAP,
    SQ_ACT,
    SQ_RULE,
    SQ_POP,
    SQ_GOTO,
    SQ_DONE
  } seq_state_t;

endpackage
`default_nettype wire

// ===== rtl/lrp_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module lrp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/lr_table_driven_parse_engine.sv =====
// Top level of the table-driven LR shift-reduce recognizer.
// Usage: items arrive on in_* with the command in in_tuser; every item gives
// exactly one result on out_* (status in out_tuser, stack depth in out_tdata).
// Load commands write the action table, the rule table or the character map.
// Start empties the state stack, pushes state 0 and makes the verdict pending.
// A character item that shifts at once passes the map read and the action lookup
// before its result, plus a rule read, stack read, goto lookup and push for every
// reduce it triggers; loads and start go straight to the result. The steps follow
// the chain of registered reads through the action, rule and stack memories.
// One item is in work at a time; the next is taken once the result is placed
// in the output register, even while that register still waits on
// out_tready. A stalled receiver holds the result and, behind it, the
// sequencer in its final step.
// After reset the action table and the character map are cleared by a pass
// of all 16384 entries (one entry per cycle) during which in_tready stays low;
// the end-symbol register (cfg_*) can be written at any time.
`default_nettype none
module lr_table_driven_parse_engine (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // tuser: cmd[2:0]
  input  wire logic [2:0]  in_tuser,
  // tdata: table_state[7:0] table_symbol[13:8] action_kind[15:14]
  //        action_value[23:16] rule_index[30:24] rule_length[34:31]
  //        rule_left[40:35] char_code[48:41] char_symbol[54:49], zero pad
  input  wire logic [55:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // tuser: status[1:0]
  output logic [1:0]       out_tuser,
  // tdata: stack_depth[8:0], zero pad
  output logic [15:0]      out_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [5:0]  cfg_data
);
  import lrp_pkg::*;

  // Input field unpacking
  logic [ST_W-1:0]    f_tstate;
  logic [SYM_W-1:0]   f_tsym;
  logic [KIND_W-1:0]  f_akind;
  logic [VAL_W-1:0]   f_aval;
  logic [6:0]         f_ridx;
  logic [LEN_W-1:0]   f_rlen;
  logic [SYM_W-1:0]   f_rleft;
  logic [CHAR_W-1:0]  f_ch;
  logic [SYM_W-1:0]   f_csym;
  cmd_e               f_cmd;

  assign f_cmd    = cmd_e'(in_tuser);
  assign f_tstate = in_tdata[7:0];
  assign f_tsym   = in_tdata[13:8];
  assign f_akind  = in_tdata[15:14];
  assign f_aval   = in_tdata[23:16];
  assign f_ridx   = in_tdata[30:24];
  assign f_rlen   = in_tdata[34:31];
  assign f_rleft  = in_tdata[40:35];
  assign f_ch     = in_tdata[48:41];
  assign f_csym   = in_tdata[54:49];

  // Registers
  seq_state_t         state_r, state_nxt;
  logic [CLR_W-1:0]   clr_cnt_r, clr_cnt_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [ST_W-1:0]    top_r, top_nxt;
  status_e            verdict_r, verdict_nxt;
  status_e            res_r, res_nxt;
  logic [SYM_W-1:0]   sym_r, sym_nxt;
  logic               at_end_r, at_end_nxt;
  logic [BUDGET_W-1:0] budget_r, budget_nxt;
  logic [CNT_W-1:0]   new_count_r, new_count_nxt;
  logic [SYM_W-1:0]   left_r, left_nxt;
  logic [SYM_W-1:0]   end_sym_r;
  logic               out_valid_r, out_valid_nxt;
  status_e            out_status_r, out_status_nxt;
  logic [CNT_W-1:0]   out_depth_r, out_depth_nxt;

  // Memory ports
  logic               act_we, rule_we, map_we, stk_we;
  logic [ACT_AW-1:0]  act_waddr, act_raddr;
  logic [ACT_W-1:0]   act_wdata, act_rd;
  logic [RULE_AW-1:0] rule_waddr, rule_raddr;
  logic [RULE_W-1:0]  rule_wdata, rule_rd;
  logic [CHAR_W-1:0]  map_waddr, map_raddr;
  logic [MAP_W-1:0]   map_wdata, map_rd;
  logic [STK_AW-1:0]  stk_waddr, stk_raddr;
  logic [ST_W-1:0]    stk_wdata, stk_rd;

  lrp_ram #(.WIDTH(ACT_W), .DEPTH(ACT_DEPTH)) u_act_ram (
    .clk(clk), .we(act_we), .waddr(act_waddr), .wdata(act_wdata),
    .raddr(act_raddr), .rdata(act_rd)
  );
  lrp_ram #(.WIDTH(RULE_W), .DEPTH(RULES)) u_rule_ram (
    .clk(clk), .we(rule_we), .waddr(rule_waddr), .wdata(rule_wdata),
    .raddr(rule_raddr), .rdata(rule_rd)
  );
  lrp_ram #(.WIDTH(MAP_W), .DEPTH(CHARS)) u_map_ram (
    .clk(clk), .we(map_we), .waddr(map_waddr), .wdata(map_wdata),
    .raddr(map_raddr), .rdata(map_rd)
  );
  lrp_ram #(.WIDTH(ST_W), .DEPTH(STACK_DEPTH)) u_stk_ram (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rd)
  );

  // Decode of the read data
  logic               in_acc;
  logic [ACT_AW-1:0]  clr_addr;
  kind_e              act_kind, goto_kind;
  logic [VAL_W-1:0]   act_val;
  logic [LEN_W-1:0]   rule_len;
  logic [SYM_W-1:0]   rule_left;
  logic [CNT_W-1:0]   pop_count, pop_count_m1;
  logic               clear_last, map_hit, shift_ok, reduce_ok, pop_ok, goto_ok;

  assign in_tready    = (state_r == SQ_IDLE);
  assign in_acc       = in_tvalid && in_tready;
  assign clr_addr     = clr_cnt_r[ACT_AW-1:0];
  assign clear_last   = (clr_cnt_r == CLR_W'(ACT_DEPTH - 1));
  assign act_kind     = kind_e'(act_rd[ACT_W-1:VAL_W]);
  assign act_val      = act_rd[VAL_W-1:0];
  assign goto_kind    = act_kind;
  assign rule_len     = rule_rd[RULE_W-1:SYM_W];
  assign rule_left    = rule_rd[SYM_W-1:0];
  assign pop_count    = count_r - CNT_W'(rule_len);
  assign pop_count_m1 = pop_count - CNT_W'(1);
  assign map_hit      = map_rd[SYM_W] && (count_r != '0);
  assign shift_ok     = !at_end_r && (count_r < CNT_W'(STACK_DEPTH));
  assign reduce_ok    = (budget_r != BUDGET_W'(REDUCE_LIMIT))
                        && ({1'b0, act_val} < (VAL_W + 1)'(RULES));
  assign pop_ok       = CNT_W'(rule_len) < count_r;
  assign goto_ok      = (goto_kind == KIND_SHIFT)
                        && (new_count_r < CNT_W'(STACK_DEPTH));

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      SQ_CLEAR: if (clear_last) state_nxt = SQ_IDLE;
      SQ_IDLE: begin
        if (in_acc) begin
          state_nxt = SQ_DONE;
          if (verdict_r == STAT_PENDING) begin
            if (f_cmd == CMD_CHAR) state_nxt = SQ_MAP;
            else if (f_cmd == CMD_END && count_r != '0) state_nxt = SQ_ACT;
          end
        end
      end
      SQ_MAP: state_nxt = map_hit ? SQ_ACT : SQ_DONE;
      SQ_ACT: state_nxt = (act_kind == KIND_REDUCE && reduce_ok) ? SQ_RULE : SQ_DONE;
      SQ_RULE: state_nxt = pop_ok ? SQ_POP : SQ_DONE;
      SQ_POP: state_nxt = SQ_GOTO;
      SQ_GOTO: state_nxt = goto_ok ? SQ_ACT : SQ_DONE;
      SQ_DONE: if (!out_valid_r || out_tready) state_nxt = SQ_IDLE;
      default: state_nxt = SQ_CLEAR;
    endcase
  end

  // Datapath and memory controls
  always_comb begin
    clr_cnt_nxt    = clr_cnt_r;
    count_nxt      = count_r;
    top_nxt        = top_r;
    verdict_nxt    = verdict_r;
    res_nxt        = res_r;
    sym_nxt        = sym_r;
    at_end_nxt     = at_end_r;
    budget_nxt     = budget_r;
    new_count_nxt  = new_count_r;
    left_nxt       = left_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_depth_nxt  = out_depth_r;
    act_we = 1'b0; act_waddr = clr_addr; act_wdata = '0;
    act_raddr = {top_r, sym_r};
    rule_we = 1'b0; rule_waddr = f_ridx; rule_wdata = {f_rlen, f_rleft};
    rule_raddr = act_val[RULE_AW-1:0];
    map_we = 1'b0; map_waddr = clr_addr[CHAR_W-1:0]; map_wdata = '0;
    map_raddr = f_ch;
    stk_we = 1'b0; stk_waddr = '0; stk_wdata = '0;
    stk_raddr = pop_count_m1[STK_AW-1:0];
    case (state_r)
      // Sweep the action table and the character map to empty
      SQ_CLEAR: begin
        act_we      = 1'b1;
        map_we      = (clr_cnt_r < CLR_W'(CHARS));
        clr_cnt_nxt = clr_cnt_r + CLR_W'(1);
      end
      SQ_IDLE: begin
        if (in_acc) begin
          res_nxt    = STAT_DONE;
          budget_nxt = '0;
          case (f_cmd)
            CMD_ACT_WR: begin
              act_we    = 1'b1;
              act_waddr = {f_tstate, f_tsym};
              act_wdata = {f_akind, f_aval};
            end
            CMD_RULE_WR: rule_we = 1'b1;
            CMD_MAP_WR: begin
              map_we    = 1'b1;
              map_waddr = f_ch;
              map_wdata = {1'b1, f_csym};
            end
            CMD_START: begin
              stk_we      = 1'b1;
              count_nxt   = CNT_W'(1);
              top_nxt     = '0;
              verdict_nxt = STAT_PENDING;
            end
            CMD_CHAR: begin
              res_nxt    = verdict_r;
              at_end_nxt = 1'b0;
            end
            CMD_END: begin
              res_nxt    = verdict_r;
              at_end_nxt = 1'b1;
              sym_nxt    = end_sym_r;
              act_raddr  = {top_r, end_sym_r};
              if (verdict_r == STAT_PENDING && count_r == '0) begin
                verdict_nxt = STAT_REJECT;
                res_nxt     = STAT_REJECT;
              end
            end
            default: res_nxt = STAT_DONE;
          endcase
        end
      end
      // Map the character, then look up the top state
      SQ_MAP: begin
        sym_nxt   = map_rd[SYM_W-1:0];
        act_raddr = {top_r, map_rd[SYM_W-1:0]};
        if (!map_hit) begin
          verdict_nxt = STAT_REJECT;
          res_nxt     = STAT_REJECT;
        end
      end
      SQ_ACT: begin
        case (act_kind)
          KIND_ACCEPT: begin
            verdict_nxt = STAT_ACCEPT;
            res_nxt     = STAT_ACCEPT;
          end
          KIND_SHIFT: begin
            if (shift_ok) begin
              stk_we    = 1'b1;
              stk_waddr = count_r[STK_AW-1:0];
              stk_wdata = act_val;
              count_nxt = count_r + CNT_W'(1);
              top_nxt   = act_val;
              res_nxt   = STAT_PENDING;
            end else begin
              verdict_nxt = STAT_REJECT;
              res_nxt     = STAT_REJECT;
            end
          end
          KIND_REDUCE: begin
            if (reduce_ok) begin
              budget_nxt = budget_r + BUDGET_W'(1);
            end else begin
              verdict_nxt = STAT_REJECT;
              res_nxt     = STAT_REJECT;
            end
          end
          default: begin
            verdict_nxt = STAT_REJECT;
            res_nxt     = STAT_REJECT;
          end
        endcase
      end
      // Pop the rule's length and read the exposed state
      SQ_RULE: begin
        new_count_nxt = pop_count;
        left_nxt      = rule_left;
        if (!pop_ok) begin
          verdict_nxt = STAT_REJECT;
          res_nxt     = STAT_REJECT;
        end
      end
      SQ_POP: act_raddr = {stk_rd, left_r};
      // Push the goto target and look up again with the same lookahead
      SQ_GOTO: begin
        act_raddr = {act_val, sym_r};
        if (goto_ok) begin
          stk_we    = 1'b1;
          stk_waddr = new_count_r[STK_AW-1:0];
          stk_wdata = act_val;
          count_nxt = new_count_r + CNT_W'(1);
          top_nxt   = act_val;
        end else begin
          count_nxt   = new_count_r;
          verdict_nxt = STAT_REJECT;
          res_nxt     = STAT_REJECT;
        end
      end
      // Hand the result to the output register
      SQ_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = (at_end_r && res_r == STAT_PENDING) ? STAT_REJECT : res_r;
          out_depth_nxt  = count_r;
          if (at_end_r && res_r == STAT_PENDING) verdict_nxt = STAT_REJECT;
        end
      end
      default: clr_cnt_nxt = '0;
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= SQ_CLEAR;
      clr_cnt_r   <= '0;
      count_r     <= '0;
      verdict_r   <= STAT_PENDING;
      res_r       <= STAT_DONE;
      at_end_r    <= 1'b0;
      budget_r    <= '0;
      out_valid_r <= 1'b0;
      end_sym_r   <= SYM_W'(63);
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      count_r     <= count_nxt;
      verdict_r   <= verdict_nxt;
      res_r       <= res_nxt;
      at_end_r    <= at_end_nxt;
      budget_r    <= budget_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) end_sym_r <= cfg_data;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    top_r        <= top_nxt;
    sym_r        <= sym_nxt;
    new_count_r  <= new_count_nxt;
    left_r       <= left_nxt;
    out_status_r <= out_status_nxt;
    out_depth_r  <= out_depth_nxt;
  end

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {{(16 - CNT_W){1'b0}}, out_depth_r};

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(STACK_DEPTH))
    else $error("stack count above depth");

  a_budget_bound: assert property (@(posedge clk) disable iff (!rst_n)
    budget_r <= BUDGET_W'(REDUCE_LIMIT))
    else $error("reduce budget overrun");

  a_final_verdict_holds_stack: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == SQ_IDLE && verdict_r != STAT_PENDING
     && !(in_acc && f_cmd == CMD_START)) |=> $stable(count_r))
    else $error("stack moved after final verdict");
`endif

endmodule
`default_nettype wire
